FILE: sv/scr_pkg.sv
// shared types, widths and helpers for the sphere collision response block
// no dependencies; scr_sqrt, scr_lane and the top level refer to it by scoped names
package scr_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned DIFF_W     = 33;
    localparam int unsigned SQ_W       = 64;
    localparam int unsigned SUM_W      = 66;
    localparam int unsigned ROOT_W     = 33;
    localparam int unsigned DIV_W      = 33;
    localparam int unsigned UNIT_Q_W   = 31;
    localparam int unsigned COEF_Q_W   = 32;
    localparam int unsigned GAP_W      = 34;
    localparam int unsigned AXES       = 3;
    localparam int unsigned IN_W       = 384;

    localparam int unsigned SQRT_STAGES = 33;
    localparam int unsigned DMAG_DLY    = 35;
    localparam int unsigned SIGN_DLY    = 66;
    localparam int unsigned CTL_DLY     = 31;
    localparam int unsigned STATE_DLY   = 68;
    localparam int unsigned PIPE_DEPTH  = 70;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_COINCIDENT = 2'd1;
    localparam logic [1:0] STATUS_SATURATED  = 2'd2;

    localparam logic [1:0] REG_OWN_MASS       = 2'd0;
    localparam logic [1:0] REG_OWN_RADIUS     = 2'd1;
    localparam logic [1:0] REG_PARTNER_MASS   = 2'd2;
    localparam logic [1:0] REG_PARTNER_RADIUS = 2'd3;

    typedef struct packed {
        logic [GAP_W-1:0]    gap;
        logic [COEF_Q_W-1:0] coef;
        logic                coin;
    } lane_ctl_t;

    typedef struct packed {
        logic [WORD_W-1:0] new_pos;
        logic [WORD_W-1:0] new_vel;
        logic              sat;
        logic              coin;
    } lane_res_t;

    // clamp a 36 bit two's complement value to 32 bits, msb of result flags clamping
    function automatic logic [32:0] sat_word(input logic [35:0] v);
        logic [32:0] r;
        if (!v[35] && (|v[34:31]))
        begin
            r = {1'b1, 32'h7FFF_FFFF};
        end
        else if (v[35] && !(&v[34:31]))
        begin
            r = {1'b1, 32'h8000_0000};
        end
        else
        begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

FILE: sv/scr_delay.sv
// shift line of N registers that holds a payload, advancing only while en is high
// generic, uses no package items
module scr_delay #(
    parameter int unsigned W = 8,
    parameter int unsigned N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] line_reg [N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= din;
            for (int j = 1; j < N; j++)
            begin
                line_reg[j] <= line_reg[j-1];
            end
        end
    end

    assign dout = line_reg[N-1];

endmodule

FILE: sv/scr_div.sv
// pipelined restoring divider, one quotient bit per stage
// dividend is {rem_init, bit_in, zeros}; generic, uses no package items
module scr_div #(
    parameter int unsigned QW = 31,
    parameter int unsigned DW = 33
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] den,
    input  logic [DW-1:0] rem_init,
    input  logic          bit_in,
    output logic [QW-1:0] quo
);

    logic [DW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [DW:0]   cand;
        logic [DW:0]   diff;

        if (s == 0)
        begin : g_first
            assign rem_in = rem_init;
            assign den_in = den;
            assign quo_in = '0;
            assign cand   = {rem_init, bit_in};
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign cand   = {rem_reg[s-1], 1'b0};
        end

        assign diff = cand - {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[s] <= den_in;
                if (cand >= {1'b0, den_in})
                begin
                    rem_reg[s] <= diff[DW-1:0];
                    quo_reg[s] <= {quo_in[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s] <= cand[DW-1:0];
                    quo_reg[s] <= {quo_in[QW-2:0], 1'b0};
                end
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

FILE: sv/scr_sqrt.sv
// pipelined integer square root of the 66 bit squared distance, one root bit per stage
// depends on scr_pkg
module scr_sqrt (
    input  logic                       clk,
    input  logic                       en,
    input  logic [scr_pkg::SUM_W-1:0]  val,
    output logic [scr_pkg::ROOT_W-1:0] root
);

    logic [33:0]                 rem_reg  [scr_pkg::SQRT_STAGES];
    logic [scr_pkg::ROOT_W-1:0]  root_reg [scr_pkg::SQRT_STAGES];
    logic [scr_pkg::SUM_W-1:0]   val_reg  [scr_pkg::SQRT_STAGES];

    for (genvar s = 0; s < scr_pkg::SQRT_STAGES; s++)
    begin : g_stage
        logic [33:0]                rem_in;
        logic [scr_pkg::ROOT_W-1:0] root_in;
        logic [scr_pkg::SUM_W-1:0]  val_in;
        logic [35:0]                remx;
        logic [35:0]                trial;
        logic [35:0]                diff;

        if (s == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = val;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign val_in  = val_reg[s-1];
        end

        assign remx  = {rem_in, val_in[65:64]};
        assign trial = {1'b0, root_in, 2'b01};
        assign diff  = remx - trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                val_reg[s] <= {val_in[63:0], 2'b00};
                if (remx >= trial)
                begin
                    rem_reg[s]  <= diff[33:0];
                    root_reg[s] <= {root_in[31:0], 1'b1};
                end
                else
                begin
                    rem_reg[s]  <= remx[33:0];
                    root_reg[s] <= {root_in[31:0], 1'b0};
                end
            end
        end
    end

    assign root = root_reg[scr_pkg::SQRT_STAGES-1];

endmodule

FILE: sv/scr_lane.sv
// one axis: squared offset, unit vector divide, position and velocity update with clamping
// depends on scr_pkg, scr_delay and scr_div
module scr_lane (
    input  logic                        clk,
    input  logic                        en,
    input  logic [scr_pkg::WORD_W-1:0]  self_pos,
    input  logic [scr_pkg::WORD_W-1:0]  other_pos,
    input  logic [scr_pkg::WORD_W-1:0]  self_vel,
    input  logic [scr_pkg::WORD_W-1:0]  other_vel,
    output logic [scr_pkg::SQ_W-1:0]    sq,
    input  logic [scr_pkg::ROOT_W-1:0]  len,
    input  scr_pkg::lane_ctl_t          ctl,
    output scr_pkg::lane_res_t          res
);

    logic [scr_pkg::DIFF_W-1:0]  d;
    logic [scr_pkg::DIFF_W-1:0]  d_abs;
    logic [scr_pkg::DIFF_W-1:0]  dv;
    logic [scr_pkg::DIFF_W-1:0]  dv_abs;
    logic [31:0]                 dmag_d;
    logic                        dneg_d;
    logic [32:0]                 dv_d;
    logic [63:0]                 state_d;
    logic [scr_pkg::UNIT_Q_W-1:0] unit_q;
    logic                        gap_neg;
    logic [scr_pkg::GAP_W-1:0]   gap_abs;
    logic [32:0]                 gap_mag;

    logic [63:0]                 sq_reg;
    logic [47:0]                 pl_reg;
    logic [46:0]                 ph_reg;
    logic                        pneg_reg;
    logic [63:0]                 vp_reg;
    logic                        vneg_reg;
    logic                        coin68_reg;
    logic                        coin69_reg;
    logic [33:0]                 pm_reg;
    logic [34:0]                 vm_reg;
    scr_pkg::lane_res_t          res_reg;

    logic [63:0]                 psum;
    logic [32:0]                 pmag;
    logic [33:0]                 vmag;
    logic [31:0]                 sp_d;
    logic [31:0]                 sv_d;
    logic [32:0]                 pos_sat;
    logic [32:0]                 vel_sat;

    assign d      = {other_pos[31], other_pos} - {self_pos[31], self_pos};
    assign d_abs  = d[32] ? (33'd0 - d) : d;
    assign dv     = {other_vel[31], other_vel} - {self_vel[31], self_vel};
    assign dv_abs = dv[32] ? (33'd0 - dv) : dv;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= 64'(d_abs[31:0]) * 64'(d_abs[31:0]);
        end
    end

    assign sq = sq_reg;

    scr_delay #(.W(32), .N(scr_pkg::DMAG_DLY)) u_dmag_dly (
        .clk  (clk),
        .en   (en),
        .din  (d_abs[31:0]),
        .dout (dmag_d)
    );

    scr_delay #(.W(1), .N(scr_pkg::SIGN_DLY)) u_dneg_dly (
        .clk  (clk),
        .en   (en),
        .din  (d[32]),
        .dout (dneg_d)
    );

    scr_delay #(.W(33), .N(scr_pkg::SIGN_DLY)) u_dv_dly (
        .clk  (clk),
        .en   (en),
        .din  ({dv[32], dv_abs[31:0]}),
        .dout (dv_d)
    );

    scr_delay #(.W(64), .N(scr_pkg::STATE_DLY)) u_state_dly (
        .clk  (clk),
        .en   (en),
        .din  ({self_vel, self_pos}),
        .dout (state_d)
    );

    scr_div #(.QW(scr_pkg::UNIT_Q_W), .DW(scr_pkg::DIV_W)) u_unit_div (
        .clk      (clk),
        .en       (en),
        .den      (len),
        .rem_init ({2'b00, dmag_d[31:1]}),
        .bit_in   (dmag_d[0]),
        .quo      (unit_q)
    );

    assign gap_neg = ctl.gap[scr_pkg::GAP_W-1];
    assign gap_abs = gap_neg ? (34'd0 - ctl.gap) : ctl.gap;
    assign gap_mag = gap_abs[32:0];

    // partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl_reg     <= 48'(unit_q) * 48'(gap_mag[16:0]);
            ph_reg     <= 47'(unit_q) * 47'(gap_mag[32:17]);
            pneg_reg   <= dneg_d ^ gap_neg;
            vp_reg     <= 64'(dv_d[31:0]) * 64'(ctl.coef);
            vneg_reg   <= dv_d[32];
            coin68_reg <= ctl.coin;
        end
    end

    assign psum = {ph_reg, 17'd0} + 64'(pl_reg);
    assign pmag = psum[63:31];
    assign vmag = vp_reg[63:30];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pm_reg     <= pneg_reg ? (34'd0 - {1'b0, pmag}) : {1'b0, pmag};
            vm_reg     <= vneg_reg ? (35'd0 - {1'b0, vmag}) : {1'b0, vmag};
            coin69_reg <= coin68_reg;
        end
    end

    assign sp_d    = state_d[31:0];
    assign sv_d    = state_d[63:32];
    assign pos_sat = scr_pkg::sat_word({{4{sp_d[31]}}, sp_d} + {{2{pm_reg[33]}}, pm_reg});
    assign vel_sat = scr_pkg::sat_word({{4{sv_d[31]}}, sv_d} + {vm_reg[34], vm_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.new_pos <= coin69_reg ? sp_d : pos_sat[31:0];
            res_reg.new_vel <= vel_sat[31:0];
            res_reg.sat     <= (pos_sat[32] && !coin69_reg) || vel_sat[32];
            res_reg.coin    <= coin69_reg;
        end
    end

    assign res = res_reg;

endmodule

FILE: sv/sphere_collision_response_top.sv
// top level of the sphere collision response block: stream ports, register port,
// distance root, three axis lanes, mass coefficient divider and status merge
// depends on scr_pkg, scr_sqrt, scr_div, scr_delay and scr_lane

// The block takes one sphere pair per clock while the output side keeps up and returns
// one result per pair, in order. The depth comes from the 33 stage square root of the
// squared center distance followed by a 31 stage divider in each axis lane that forms
// the unit vector, plus the multiply and clamp stages. A stall on the output holds the
// whole pipeline, so s_tready follows m_tready while a result is waiting. The mass ratio
// is formed by a free-running 32 stage divider from the mass registers; the user must
// write registers only while no pair is in flight, which the block does not enforce.
module sphere_collision_response_top #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // self_pos_x/y/z, other_pos_x/y/z, self_vel_x/y/z, other_vel_x/y/z
    input  logic [383:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_pos_x/y/z, new_vel_x/y/z, status, zero pad
    output logic [199:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

    logic                en;
    logic [31:0]         own_mass_reg;
    logic [30:0]         own_radius_reg;
    logic [31:0]         partner_mass_reg;
    logic [30:0]         partner_radius_reg;

    logic [scr_pkg::IN_W-1:0]   in_reg;
    logic                       vld_reg [scr_pkg::PIPE_DEPTH];
    logic [scr_pkg::SUM_W-1:0]  sum_reg;
    logic [scr_pkg::SQ_W-1:0]   sq [scr_pkg::AXES];
    logic [scr_pkg::ROOT_W-1:0] len;
    logic [32:0]                rsum;
    logic [scr_pkg::GAP_W-1:0]  gap;
    logic [scr_pkg::GAP_W:0]    gap_coin_d;
    logic [32:0]                msum;
    logic [scr_pkg::COEF_Q_W-1:0] coef_q;
    scr_pkg::lane_ctl_t         ctl;
    scr_pkg::lane_res_t         res [scr_pkg::AXES];

    logic                       out_vld_reg;
    logic [191:0]               out_data_reg;
    logic [1:0]                 out_status_reg;

    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;
    assign pready   = 1'b1;

    // register port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mass_reg       <= ONE;
            own_radius_reg     <= ONE[30:0];
            partner_mass_reg   <= ONE;
            partner_radius_reg <= ONE[30:0];
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                scr_pkg::REG_OWN_MASS:       own_mass_reg       <= pwdata;
                scr_pkg::REG_OWN_RADIUS:     own_radius_reg     <= pwdata[30:0];
                scr_pkg::REG_PARTNER_MASS:   partner_mass_reg   <= pwdata;
                scr_pkg::REG_PARTNER_RADIUS: partner_radius_reg <= pwdata[30:0];
                default:                     own_mass_reg       <= own_mass_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            scr_pkg::REG_OWN_MASS:       prdata = own_mass_reg;
            scr_pkg::REG_OWN_RADIUS:     prdata = {1'b0, own_radius_reg};
            scr_pkg::REG_PARTNER_MASS:   prdata = partner_mass_reg;
            scr_pkg::REG_PARTNER_RADIUS: prdata = {1'b0, partner_radius_reg};
            default:                     prdata = '0;
        endcase
    end

    // beat valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < scr_pkg::PIPE_DEPTH; j++)
            begin
                vld_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int j = 1; j < scr_pkg::PIPE_DEPTH; j++)
            begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg  <= s_tdata;
            sum_reg <= 66'(sq[0]) + 66'(sq[1]) + 66'(sq[2]);
        end
    end

    scr_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .val  (sum_reg),
        .root (len)
    );

    assign rsum = 33'(own_radius_reg) + 33'(partner_radius_reg);
    assign gap  = 34'(len) - 34'(rsum);

    scr_delay #(.W(scr_pkg::GAP_W + 1), .N(scr_pkg::CTL_DLY)) u_ctl_dly (
        .clk  (clk),
        .en   (en),
        .din  ({gap, (len == '0)}),
        .dout (gap_coin_d)
    );

    assign msum = 33'(own_mass_reg) + 33'(partner_mass_reg);

    scr_div #(.QW(scr_pkg::COEF_Q_W), .DW(scr_pkg::DIV_W)) u_coef_div (
        .clk      (clk),
        .en       (1'b1),
        .den      (msum),
        .rem_init ({2'b00, partner_mass_reg[31:1]}),
        .bit_in   (partner_mass_reg[0]),
        .quo      (coef_q)
    );

    assign ctl.gap  = gap_coin_d[scr_pkg::GAP_W:1];
    assign ctl.coin = gap_coin_d[0];
    assign ctl.coef = (msum == '0) ? '0 : coef_q;

    for (genvar i = 0; i < scr_pkg::AXES; i++)
    begin : g_lane
        scr_lane u_lane (
            .clk       (clk),
            .en        (en),
            .self_pos  (in_reg[32*i +: 32]),
            .other_pos (in_reg[96 + 32*i +: 32]),
            .self_vel  (in_reg[192 + 32*i +: 32]),
            .other_vel (in_reg[288 + 32*i +: 32]),
            .sq        (sq[i]),
            .len       (len),
            .ctl       (ctl),
            .res       (res[i])
        );
    end

    // merge lanes into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vld_reg[scr_pkg::PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {res[2].new_vel, res[1].new_vel, res[0].new_vel,
                             res[2].new_pos, res[1].new_pos, res[0].new_pos};
            if (res[0].coin)
            begin
                out_status_reg <= scr_pkg::STATUS_COINCIDENT;
            end
            else if (res[0].sat || res[1].sat || res[2].sat)
            begin
                out_status_reg <= scr_pkg::STATUS_SATURATED;
            end
            else
            begin
                out_status_reg <= scr_pkg::STATUS_OK;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, out_status_reg, out_data_reg};

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> !(out_status_reg[0] && out_status_reg[1]))
        else $error("status code out of range");

    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(vld_reg[scr_pkg::PIPE_DEPTH-1]))
        else $error("output valid without a beat at the pipeline end");

    a_pipe_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(vld_reg[0]) |-> $past(s_tvalid && s_tready))
        else $error("pipeline entry valid without an accepted beat");

endmodule
